// File: rtl/iafs_pkg.sv
// Package for the index allocator with free stack.
// Widths, capacity, operation and status codes, and the types shared by the
// top level and its divider unit. No dependencies.
package iafs_pkg;

	// Number of indices the allocator can hand out fresh; also the stack depth.
	localparam int CAPACITY = 4096;

	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 13;
	localparam int BLK_W      = 12;
	localparam int OFF_W      = 22;
	localparam int ST_W       = 2;
	localparam int EPB_W      = 13;
	localparam int ESZ_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);

	localparam int DIV_W     = IDX_W;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int PROD_W    = DIV_W + ESZ_W;

	localparam logic [EPB_W-1:0] EPB_RST = EPB_W'(256);
	localparam logic [ESZ_W-1:0] ESZ_RST = ESZ_W'(16);

	localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_LOCATE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EXHAUST  = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_EPB = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ESZ = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// File: rtl/iafs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module iafs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/iafs_div.sv
// Iterative restoring divider, one quotient bit per cycle, followed by one
// multiply of the remainder by the element size. Depends on iafs_pkg.
module iafs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iafs_pkg::div_ctl_t                ctl,
	input  logic [iafs_pkg::EPB_W-1:0]        divisor,
	input  logic [iafs_pkg::ESZ_W-1:0]        esz,
	output iafs_pkg::div_sts_t                sts,
	output logic [iafs_pkg::BLK_W-1:0]        quot,
	output logic [iafs_pkg::OFF_W-1:0]        off
);

	logic                               busy_q;
	logic                               done_q;
	logic [iafs_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [iafs_pkg::DIV_W-1:0]         rem_q;
	logic [iafs_pkg::DIV_W-1:0]         quo_q;
	logic [iafs_pkg::OFF_W-1:0]         off_q;
	logic [iafs_pkg::DIV_W:0]           trial;
	logic [iafs_pkg::DIV_W:0]           diff;
	logic [iafs_pkg::PROD_W-1:0]        prod;

	// A zero divisor never borrows, so the quotient fills with ones and the
	// remainder ends equal to the dividend.
	assign trial = {rem_q, quo_q[iafs_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign prod  = iafs_pkg::PROD_W'(rem_q) * iafs_pkg::PROD_W'(esz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= iafs_pkg::DIV_CNT_W'(iafs_pkg::DIV_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= ctl.dividend;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (!diff[iafs_pkg::DIV_W]) begin
					rem_q <= diff[iafs_pkg::DIV_W-1:0];
					quo_q <= {quo_q[iafs_pkg::DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[iafs_pkg::DIV_W-1:0];
					quo_q <= {quo_q[iafs_pkg::DIV_W-2:0], 1'b0};
				end
			end else begin
				off_q <= iafs_pkg::OFF_W'(prod);
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quo_q[iafs_pkg::BLK_W-1:0];
	assign off      = off_q;

endmodule

// File: rtl/index_allocator_free_stack_core.sv
// Top level of the index allocator: sequencer, free stack, counters and the
// configuration registers. Depends on iafs_pkg, iafs_ram and iafs_div.
// From input transfer to result valid: a fresh or exhausted allocate, a free,
// a null index or an unused operation goes through S_RESULT alone, an allocate
// popped from the stack through S_POP and S_RESULT, and a locate through S_DIV,
// which lasts until the divider is done, and S_RESULT. One item is in work at a
// time; the next is accepted in the cycle after its result is loaded.
// Reset empties the stack and restores the fresh sequence and defaults at once.
module index_allocator_free_stack_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [iafs_pkg::FUNC_W-1:0]        func,
	input  logic [iafs_pkg::IDX_W-1:0]         idx,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [iafs_pkg::IDX_W-1:0]         result_idx,
	output logic [iafs_pkg::BLK_W-1:0]         block_index,
	output logic [iafs_pkg::OFF_W-1:0]         byte_offset,
	output logic                               is_null,
	output logic [iafs_pkg::ST_W-1:0]          status,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [iafs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [iafs_pkg::CFG_DATA_W-1:0]    cfg_value
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_POP    = 2'd1;
	localparam logic [1:0] S_DIV    = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0]                     state_q;
	logic [iafs_pkg::CNT_W-1:0]     free_cnt_q;
	logic [iafs_pkg::CNT_W-1:0]     fresh_cnt_q;
	logic [iafs_pkg::EPB_W-1:0]     epb_q;
	logic [iafs_pkg::ESZ_W-1:0]     esz_q;
	logic                           out_valid_q;

	logic [iafs_pkg::IDX_W-1:0]     pend_idx_q;
	logic [iafs_pkg::BLK_W-1:0]     pend_blk_q;
	logic [iafs_pkg::OFF_W-1:0]     pend_off_q;
	logic                           pend_nul_q;
	logic [iafs_pkg::ST_W-1:0]      pend_st_q;

	logic [iafs_pkg::IDX_W-1:0]     out_idx_q;
	logic [iafs_pkg::BLK_W-1:0]     out_blk_q;
	logic [iafs_pkg::OFF_W-1:0]     out_off_q;
	logic                           out_nul_q;
	logic [iafs_pkg::ST_W-1:0]      out_st_q;

	logic                           in_xfer;
	logic                           out_free;
	logic                           stack_empty;
	logic                           stack_full;
	logic                           fresh_done;
	logic                           idx_zero;
	logic [iafs_pkg::CNT_W-1:0]     free_dec;
	logic [iafs_pkg::CNT_W-1:0]     fresh_inc;
	logic                           ram_we;
	logic                           ram_re;
	logic [iafs_pkg::IDX_W-1:0]     ram_rdata;
	iafs_pkg::div_ctl_t             div_ctl;
	iafs_pkg::div_sts_t             div_sts;
	logic [iafs_pkg::BLK_W-1:0]     div_quot;
	logic [iafs_pkg::OFF_W-1:0]     div_off;

	assign in_ready    = (state_q == S_IDLE);
	assign in_xfer     = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign cfg_ready   = 1'b1;
	assign stack_empty = (free_cnt_q == '0);
	assign stack_full  = (free_cnt_q >= iafs_pkg::CNT_W'(iafs_pkg::CAPACITY));
	assign fresh_done  = (fresh_cnt_q >= iafs_pkg::CNT_W'(iafs_pkg::CAPACITY));
	assign idx_zero    = (idx == '0);
	assign free_dec    = free_cnt_q - 1'b1;
	assign fresh_inc   = fresh_cnt_q + 1'b1;

	assign ram_we = in_xfer && (func == iafs_pkg::FN_FREE) && !idx_zero && !stack_full;
	assign ram_re = in_xfer && (func == iafs_pkg::FN_ALLOC) && !stack_empty;

	assign div_ctl.start    = in_xfer && (func == iafs_pkg::FN_LOCATE) && !idx_zero;
	assign div_ctl.dividend = idx - 1'b1;

	// The stack pointer stays below the depth whenever it addresses the RAM.
	iafs_ram #(
		.WIDTH(iafs_pkg::IDX_W),
		.DEPTH(iafs_pkg::CAPACITY)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_cnt_q[iafs_pkg::ADDR_W-1:0]),
		.wdata(idx),
		.re   (ram_re),
		.raddr(free_dec[iafs_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	iafs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.divisor(epb_q),
		.esz    (esz_q),
		.sts    (div_sts),
		.quot   (div_quot),
		.off    (div_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epb_q <= iafs_pkg::EPB_RST;
			esz_q <= iafs_pkg::ESZ_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				iafs_pkg::REG_EPB: epb_q <= cfg_value[iafs_pkg::EPB_W-1:0];
				iafs_pkg::REG_ESZ: esz_q <= cfg_value[iafs_pkg::ESZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_cnt_q  <= '0;
			fresh_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_RESULT;
						unique case (func)
							iafs_pkg::FN_ALLOC: begin
								if (!stack_empty) begin
									free_cnt_q <= free_dec;
									state_q    <= S_POP;
								end else if (!fresh_done) begin
									fresh_cnt_q <= fresh_inc;
								end
							end
							iafs_pkg::FN_FREE: begin
								if (ram_we) begin
									free_cnt_q <= free_cnt_q + 1'b1;
								end
							end
							iafs_pkg::FN_LOCATE: begin
								if (!idx_zero) begin
									state_q <= S_DIV;
								end
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					state_q <= S_RESULT;
				end
				S_DIV: begin
					if (div_sts.done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Pending result fields, built while the item is in work.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_idx_q <= '0;
			pend_blk_q <= '0;
			pend_off_q <= '0;
			pend_nul_q <= 1'b0;
			pend_st_q  <= iafs_pkg::ST_OK;
			unique case (func)
				iafs_pkg::FN_ALLOC: begin
					if (stack_empty) begin
						if (fresh_done) begin
							pend_st_q <= iafs_pkg::ST_EXHAUST;
						end else begin
							pend_idx_q <= iafs_pkg::IDX_W'(fresh_inc);
						end
					end
				end
				iafs_pkg::FN_FREE: begin
					if (idx_zero) begin
						pend_nul_q <= 1'b1;
					end else if (stack_full) begin
						pend_st_q <= iafs_pkg::ST_OVERFLOW;
					end
				end
				iafs_pkg::FN_LOCATE: begin
					pend_nul_q <= idx_zero;
				end
				default: ;
			endcase
		end else if (state_q == S_POP) begin
			pend_idx_q <= ram_rdata;
		end else if (state_q == S_DIV && div_sts.done) begin
			pend_blk_q <= div_quot;
			pend_off_q <= div_off;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			out_idx_q <= pend_idx_q;
			out_blk_q <= pend_blk_q;
			out_off_q <= pend_off_q;
			out_nul_q <= pend_nul_q;
			out_st_q  <= pend_st_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_idx  = out_idx_q;
	assign block_index = out_blk_q;
	assign byte_offset = out_off_q;
	assign is_null     = out_nul_q;
	assign status      = out_st_q;

	a_free_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= iafs_pkg::CNT_W'(iafs_pkg::CAPACITY))
		else $error("free stack count beyond capacity");

	a_fresh_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_cnt_q <= iafs_pkg::CNT_W'(iafs_pkg::CAPACITY))
		else $error("fresh index count beyond capacity");

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_sts.busy)
		else $error("input ready while the divider is still busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == S_DIV))
		else $error("divider finished outside the locate phase");

	a_result_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && !out_valid_q) |=> out_valid_q)
		else $error("finished result not moved into an empty output register");

endmodule
